>>> src/cbq_pkg.sv
`default_nettype none
package cbq_pkg;

	localparam int SECTIONS_DEF       = 3;
	localparam int COEF_FRAC_BITS_DEF = 22;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 24;
	localparam int HIST_W    = 32;
	localparam int HIST_FRAC = 8;
	localparam int OPND_W    = 32;
	localparam int PROD_W    = COEF_W + OPND_W;
	localparam int ACC_W     = PROD_W + 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_W;
	localparam int SEL_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SECTIONS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B0       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B1       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B2       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2       = 3'd5;

	localparam logic signed [ACC_W-1:0] SAMPLE_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] INT32_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] INT32_MIN = -ACC_W'(64'sd2147483648);

	typedef struct packed {
		logic issue;
		logic first;
		logic sub;
	} mac_ctl_t;

	typedef struct packed {
		logic signed [HIST_W-1:0]   yh;
		logic signed [SAMPLE_W-1:0] o;
		logic                       clip;
	} post_res_t;

endpackage
`default_nettype wire

>>> src/cbq_if.sv
`default_nettype none
interface cbq_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in;
	logic                                 start_of_stream;

	modport source(output valid, sample_in, start_of_stream, input ready);
	modport sink(input valid, sample_in, start_of_stream, output ready);
endinterface

interface cbq_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out;
	logic                                 clipped;

	modport source(output valid, sample_out, clipped, input ready);
	modport sink(input valid, sample_out, clipped, output ready);
endinterface
`default_nettype wire

>>> src/cbq_mac.sv
`default_nettype none
module cbq_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cbq_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [cbq_pkg::COEF_W-1:0]  coef,
	input  wire logic signed [cbq_pkg::OPND_W-1:0]  opnd,
	output logic signed [cbq_pkg::ACC_W-1:0]        acc
);

	logic signed [cbq_pkg::PROD_W-1:0] prod;
	logic signed [cbq_pkg::PROD_W-1:0] prod_s1;
	cbq_pkg::mac_ctl_t                 ctl_s1;
	logic signed [cbq_pkg::ACC_W-1:0]  acc_q;
	logic signed [cbq_pkg::ACC_W-1:0]  term;
	logic signed [cbq_pkg::ACC_W-1:0]  base;

	assign prod = coef * opnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= prod;
		end
	end

	assign term = cbq_pkg::ACC_W'(prod_s1);
	assign base = ctl_s1.first ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl_s1.issue) begin
			acc_q <= ctl_s1.sub ? base - term : base + term;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

>>> src/cbq_post.sv
`default_nettype none
module cbq_post #(
	parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               take,
	input  wire logic signed [cbq_pkg::ACC_W-1:0]  acc,
	output cbq_pkg::post_res_t                      res
);

	localparam logic signed [cbq_pkg::ACC_W-1:0] FRAC_MASK =
		(cbq_pkg::ACC_W'(1) <<< COEF_FRAC_BITS) - cbq_pkg::ACC_W'(1);
	localparam logic signed [cbq_pkg::ACC_W-1:0] HIST_MASK =
		(cbq_pkg::ACC_W'(1) <<< cbq_pkg::HIST_FRAC) - cbq_pkg::ACC_W'(1);

	logic signed [cbq_pkg::ACC_W-1:0] rnd;
	logic signed [cbq_pkg::ACC_W-1:0] y8_s1;
	logic signed [cbq_pkg::ACC_W-1:0] yh_sat;
	logic signed [cbq_pkg::ACC_W-1:0] o_full;

	// truncate toward zero: bias negative values before the arithmetic shift
	assign rnd = acc + (acc[cbq_pkg::ACC_W-1] ? FRAC_MASK : '0);

	always_ff @(posedge clk) begin
		if (take) begin
			y8_s1 <= rnd >>> COEF_FRAC_BITS;
		end
	end

	assign o_full = $signed(y8_s1 + (y8_s1[cbq_pkg::ACC_W-1] ? HIST_MASK : '0))
		>>> cbq_pkg::HIST_FRAC;

	always_comb begin
		if (y8_s1 > cbq_pkg::INT32_MAX) begin
			yh_sat = cbq_pkg::INT32_MAX;
		end else if (y8_s1 < cbq_pkg::INT32_MIN) begin
			yh_sat = cbq_pkg::INT32_MIN;
		end else begin
			yh_sat = y8_s1;
		end
		res.yh = yh_sat[cbq_pkg::HIST_W-1:0];
		if (o_full > cbq_pkg::SAMPLE_MAX) begin
			res.o    = cbq_pkg::SAMPLE_MAX[cbq_pkg::SAMPLE_W-1:0];
			res.clip = 1'b1;
		end else if (o_full < cbq_pkg::SAMPLE_MIN) begin
			res.o    = cbq_pkg::SAMPLE_MIN[cbq_pkg::SAMPLE_W-1:0];
			res.clip = 1'b1;
		end else begin
			res.o    = o_full[cbq_pkg::SAMPLE_W-1:0];
			res.clip = 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> src/cascaded_biquad_iir_filter.sv
// Channel  Dir  Payload                              Handshake
// feed     in   sample_in[15:0] s, start_of_stream   feed.valid / feed.ready
// result   out  sample_out[15:0] s, clipped          result.valid / result.ready
// cfg      in   cfg_index[2:0], cfg_data[23:0]       cfg_we, no back-pressure
//
// One 24x32 multiplier and accumulator serve every product. Each section steps through
// five products, one step to close the sum, then truncation and saturation.
// The result register loads once the last of the N sections in use (1..3) has
// written back and the register is free; the next item is accepted only after
// that load. feed.ready is high only when the
// sequencer is idle. The result register holds its item until taken;
// a finished item waits in the sequencer while the register is full.
// Reset clears histories and control at once and sets the configuration to its defaults.
`default_nettype none
module cascaded_biquad_iir_filter #(
	parameter int SECTIONS       = cbq_pkg::SECTIONS_DEF,
	parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	cbq_in_if.sink                                     feed,
	cbq_out_if.source                                  result,
	input  wire logic                                  cfg_we,
	input  wire logic [cbq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [cbq_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int CNT_W = $clog2(SECTIONS + 1);
	localparam int CMP_W = (CNT_W > cbq_pkg::SEL_W) ? CNT_W : cbq_pkg::SEL_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam logic [2:0] STEP_B0   = 3'd0;
	localparam logic [2:0] STEP_B1   = 3'd1;
	localparam logic [2:0] STEP_B2   = 3'd2;
	localparam logic [2:0] STEP_A1   = 3'd3;
	localparam logic [2:0] STEP_A2   = 3'd4;
	localparam logic [2:0] STEP_LAST = 3'd5;
	localparam logic [2:0] STEP_POST = 3'd6;
	localparam logic [2:0] STEP_WB   = 3'd7;

	localparam int XPAD = cbq_pkg::OPND_W - cbq_pkg::SAMPLE_W - cbq_pkg::HIST_FRAC;

	logic [cbq_pkg::SEL_W-1:0]          sections_q;
	logic signed [cbq_pkg::COEF_W-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;

	logic signed [cbq_pkg::SAMPLE_W-1:0] in_h1_q  [SECTIONS];
	logic signed [cbq_pkg::SAMPLE_W-1:0] in_h2_q  [SECTIONS];
	logic signed [cbq_pkg::HIST_W-1:0]   out_h1_q [SECTIONS];
	logic signed [cbq_pkg::HIST_W-1:0]   out_h2_q [SECTIONS];

	logic [1:0]                          state_q;
	logic [2:0]                          step_q;
	logic [IDX_W-1:0]                    sec_q;
	logic [CNT_W-1:0]                    count_q;
	logic signed [cbq_pkg::SAMPLE_W-1:0] cur_q;
	logic                                clip_q;

	logic                                out_valid_q;
	logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                clipped_q;

	logic                                accept;
	logic                                last_sec;
	logic                                out_free;
	logic [CMP_W-1:0]                    req_cnt;
	logic [CNT_W-1:0]                    count_d;

	cbq_pkg::mac_ctl_t                   mac_ctl;
	logic signed [cbq_pkg::COEF_W-1:0]   coef;
	logic signed [cbq_pkg::OPND_W-1:0]   opnd;
	logic signed [cbq_pkg::ACC_W-1:0]    acc;
	cbq_pkg::post_res_t                  res;

	assign accept   = feed.valid && feed.ready;
	assign feed.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || result.ready;
	assign last_sec = ((CNT_W'(sec_q) + CNT_W'(1)) == count_q);

	// zero sections means one; more than built means all built
	assign req_cnt = CMP_W'(sections_q);
	always_comb begin
		if (req_cnt == '0) begin
			count_d = CNT_W'(1);
		end else if (req_cnt > CMP_W'(SECTIONS)) begin
			count_d = CNT_W'(SECTIONS);
		end else begin
			count_d = req_cnt[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sections_q <= 2'd3;
			b0_q       <= 24'sd4194304;
			b1_q       <= '0;
			b2_q       <= '0;
			a1_q       <= '0;
			a2_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbq_pkg::REG_SECTIONS: sections_q <= cfg_data[cbq_pkg::SEL_W-1:0];
				cbq_pkg::REG_B0:       b0_q <= cfg_data;
				cbq_pkg::REG_B1:       b1_q <= cfg_data;
				cbq_pkg::REG_B2:       b2_q <= cfg_data;
				cbq_pkg::REG_A1:       a1_q <= cfg_data;
				cbq_pkg::REG_A2:       a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// select the product for this step
	always_comb begin
		unique case (step_q)
			STEP_B0: begin
				coef = b0_q;
				opnd = {{XPAD{cur_q[cbq_pkg::SAMPLE_W-1]}}, cur_q,
					cbq_pkg::HIST_FRAC'(0)};
			end
			STEP_B1: begin
				coef = b1_q;
				opnd = {{XPAD{in_h1_q[sec_q][cbq_pkg::SAMPLE_W-1]}}, in_h1_q[sec_q],
					cbq_pkg::HIST_FRAC'(0)};
			end
			STEP_B2: begin
				coef = b2_q;
				opnd = {{XPAD{in_h2_q[sec_q][cbq_pkg::SAMPLE_W-1]}}, in_h2_q[sec_q],
					cbq_pkg::HIST_FRAC'(0)};
			end
			STEP_A1: begin
				coef = a1_q;
				opnd = cbq_pkg::OPND_W'(out_h1_q[sec_q]);
			end
			STEP_A2: begin
				coef = a2_q;
				opnd = cbq_pkg::OPND_W'(out_h2_q[sec_q]);
			end
			default: begin
				coef = '0;
				opnd = '0;
			end
		endcase
	end

	assign mac_ctl.issue = (state_q == ST_RUN) && (step_q < STEP_LAST);
	assign mac_ctl.first = (step_q == STEP_B0);
	assign mac_ctl.sub   = (step_q == STEP_A1) || (step_q == STEP_A2);

	cbq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef),
		.opnd   (opnd),
		.acc    (acc)
	);

	cbq_post #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_post (
		.clk  (clk),
		.take ((state_q == ST_RUN) && (step_q == STEP_POST)),
		.acc  (acc),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SECTIONS; i++) begin
				in_h1_q[i]  <= '0;
				in_h2_q[i]  <= '0;
				out_h1_q[i] <= '0;
				out_h2_q[i] <= '0;
			end
		end else if (accept && feed.start_of_stream) begin
			for (int i = 0; i < SECTIONS; i++) begin
				in_h1_q[i]  <= '0;
				in_h2_q[i]  <= '0;
				out_h1_q[i] <= '0;
				out_h2_q[i] <= '0;
			end
		end else if ((state_q == ST_RUN) && (step_q == STEP_WB)) begin
			in_h2_q[sec_q]  <= in_h1_q[sec_q];
			in_h1_q[sec_q]  <= cur_q;
			out_h2_q[sec_q] <= out_h1_q[sec_q];
			out_h1_q[sec_q] <= res.yh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_B0;
			sec_q   <= '0;
			count_q <= CNT_W'(1);
			cur_q   <= '0;
			clip_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= STEP_B0;
						sec_q   <= '0;
						count_q <= count_d;
						cur_q   <= feed.sample_in;
						clip_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_WB) begin
						cur_q  <= res.o;
						clip_q <= clip_q | res.clip;
						if (last_sec) begin
							state_q <= ST_FLUSH;
						end else begin
							sec_q <= sec_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FLUSH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FLUSH) && out_free) begin
			sample_out_q <= cur_q;
			clipped_q    <= clip_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = sample_out_q;
	assign result.clipped    = clipped_q;

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (step_q == STEP_B0) && (sec_q == '0))
		else $error("accepted item did not start the sequencer");

	a_sec_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (CNT_W'(sec_q) < count_q))
		else $error("section index beyond sections in use");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (count_q != '0) && (count_q <= CNT_W'(SECTIONS)))
		else $error("section count out of range");

	a_flush_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) && out_free |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished item not loaded into the result register");

	a_wb_last_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (step_q == STEP_WB) && last_sec |=> (state_q == ST_FLUSH))
		else $error("last section write-back did not end the item");

endmodule
`default_nettype wire

>>> test/cascaded_biquad_iir_filter_tb.sv
`timescale 1ns / 100ps
module cascaded_biquad_iir_filter_tb;

	localparam int SECTIONS     = cbq_pkg::SECTIONS_DEF;
	localparam int COEF_ONE     = 1 << cbq_pkg::COEF_FRAC_BITS_DEF;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int QUIET_LIMIT  = 3000;
	localparam int PLAN_ROWS    = 29;

	localparam int CFG_IDX_W  = cbq_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = cbq_pkg::CFG_DATA_W;
	localparam int COEF_W     = cbq_pkg::COEF_W;
	localparam int SAMPLE_W   = cbq_pkg::SAMPLE_W;
	localparam int SEL_W      = cbq_pkg::SEL_W;
	localparam int HIST_W     = cbq_pkg::HIST_W;
	localparam int HIST_FRAC  = cbq_pkg::HIST_FRAC;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [CFG_IDX_W-1:0]       idx;
		logic [CFG_DATA_W-1:0]      data;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sos;
		logic                       known;
		logic signed [SAMPLE_W-1:0] want;
		logic                       want_clip;
	} plan_row_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clip;
	} filtered_t;

	typedef struct packed {
		logic [SEL_W-1:0]         sections;
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} filter_cfg_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	cbq_in_if  feed();
	cbq_out_if result();

	cascaded_biquad_iir_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of configuration and section histories
	logic [SEL_W-1:0]          k_sections;
	logic signed [COEF_W-1:0]  k_b0, k_b1, k_b2, k_a1, k_a2;
	logic signed [SAMPLE_W-1:0] x1_h [SECTIONS];
	logic signed [SAMPLE_W-1:0] x2_h [SECTIONS];
	logic signed [HIST_W-1:0]   y1_h [SECTIONS];
	logic signed [HIST_W-1:0]   y2_h [SECTIONS];

	filtered_t awaited[$];
	plan_row_t plan [PLAN_ROWS];

	int errors        = 0;
	int results_seen  = 0;
	int hold_trigger  = -1;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int quiet_cycles  = 0;

	function automatic void clear_history();
		int s;
		for (s = 0; s < SECTIONS; s++) begin
			x1_h[s] = '0;
			x2_h[s] = '0;
			y1_h[s] = '0;
			y2_h[s] = '0;
		end
	endfunction

	function automatic filtered_t run_cascade(input logic signed [SAMPLE_W-1:0] x,
			input logic sos);
		filtered_t r;
		longint cur, ff, acc, y8, yh;
		int n, s;
		cur = longint'(x);
		r.clip = 1'b0;
		if (sos)
			clear_history();
		n = (k_sections == '0) ? 1 : int'(k_sections);
		if (n > SECTIONS)
			n = SECTIONS;
		for (s = 0; s < n; s++) begin
			ff = longint'(k_b0) * cur + longint'(k_b1) * longint'(x1_h[s])
				+ longint'(k_b2) * longint'(x2_h[s]);
			acc = ff * (longint'(1) << HIST_FRAC) - longint'(k_a1) * longint'(y1_h[s])
				- longint'(k_a2) * longint'(y2_h[s]);
			// signed division truncates toward zero
			y8 = acc / longint'(COEF_ONE);
			yh = y8;
			if (yh > longint'(cbq_pkg::INT32_MAX))
				yh = longint'(cbq_pkg::INT32_MAX);
			if (yh < longint'(cbq_pkg::INT32_MIN))
				yh = longint'(cbq_pkg::INT32_MIN);
			x2_h[s] = x1_h[s];
			x1_h[s] = SAMPLE_W'(cur);
			y2_h[s] = y1_h[s];
			y1_h[s] = HIST_W'(yh);
			cur = y8 / (longint'(1) << HIST_FRAC);
			if (cur > longint'(cbq_pkg::SAMPLE_MAX)) begin
				cur = longint'(cbq_pkg::SAMPLE_MAX);
				r.clip = 1'b1;
			end else if (cur < longint'(cbq_pkg::SAMPLE_MIN)) begin
				cur = longint'(cbq_pkg::SAMPLE_MIN);
				r.clip = 1'b1;
			end
		end
		r.sample = SAMPLE_W'(cur);
		return r;
	endfunction

	// Poles kept inside the stability triangle, feedforward taps within +/- gain
	function automatic filter_cfg_t stable_setting(input logic [SEL_W-1:0] sec, input int gain);
		filter_cfg_t c;
		int pole2, span;
		pole2 = int'($urandom_range(COEF_ONE / 100 * 95));
		span = (COEF_ONE + pole2) / 100 * 95;
		c.sections = sec;
		c.a2 = COEF_W'(pole2);
		c.a1 = COEF_W'(int'($urandom_range(2 * span)) - span);
		c.b0 = COEF_W'(int'($urandom_range(2 * gain)) - gain);
		c.b1 = COEF_W'(int'($urandom_range(2 * gain)) - gain);
		c.b2 = COEF_W'(int'($urandom_range(2 * gain)) - gain);
		return c;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return SAMPLE_W'($urandom_range(511) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
		return '{ROW_CFG, idx, CFG_DATA_W'(data), '0, 1'b0, 1'b0, '0, 1'b0};
	endfunction

	function automatic plan_row_t item_row(input int x, input bit sos);
		return '{ROW_ITEM, '0, '0, SAMPLE_W'(x), sos, 1'b0, '0, 1'b0};
	endfunction

	function automatic plan_row_t known_row(input int x, input bit sos, input int want,
			input bit clip);
		return '{ROW_ITEM, '0, '0, SAMPLE_W'(x), sos, 1'b1, SAMPLE_W'(want), clip};
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			cbq_pkg::REG_SECTIONS: k_sections = data[SEL_W-1:0];
			cbq_pkg::REG_B0:       k_b0 = data;
			cbq_pkg::REG_B1:       k_b1 = data;
			cbq_pkg::REG_B2:       k_b2 = data;
			cbq_pkg::REG_A1:       k_a1 = data;
			cbq_pkg::REG_A2:       k_a2 = data;
			default:      ; // indexes past the last register are ignored
		endcase
	endtask

	// Called just after a falling edge; returns just after the falling edge that
	// follows acceptance, with valid still high.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic sos,
			input logic known, input filtered_t typed);
		filtered_t f;
		while ($urandom_range(99) < tx_idle_pct) begin
			feed.valid <= 1'b0;
			@(negedge clk);
		end
		feed.valid           <= 1'b1;
		feed.sample_in       <= x;
		feed.start_of_stream <= sos;
		do
			@(posedge clk);
		while (!feed.ready);
		f = run_cascade(x, sos);
		awaited.push_back(known ? typed : f);
		@(negedge clk);
	endtask

	task automatic drain();
		feed.valid <= 1'b0;
		while (awaited.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off mid-run to fill the block
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_used && results_seen == hold_trigger) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				result.ready <= 1'b0;
				hold_left--;
			end else
				result.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		filtered_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			results_seen++;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with nothing awaited, sample_out %0d clipped %0b",
					$time, result.sample_out, result.clipped);
			end else begin
				exp_r = awaited.pop_front();
				if (result.sample_out !== exp_r.sample) begin
					errors++;
					$display("%0t: sample_out expected %0d, got %0d",
						$time, exp_r.sample, result.sample_out);
				end
				if (result.clipped !== exp_r.clip) begin
					errors++;
					$display("%0t: clipped expected %0b, got %0b",
						$time, exp_r.clip, result.clipped);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (feed.valid && feed.ready) || (result.valid && result.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		filter_cfg_t setting;
		int n_items, p, i, r;
		feed.valid           = 1'b0;
		feed.sample_in       = '0;
		feed.start_of_stream = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;

		k_sections = 2'd3;
		k_b0 = COEF_W'(COEF_ONE);
		k_b1 = '0;
		k_b2 = '0;
		k_a1 = '0;
		k_a2 = '0;
		clear_history();

		// Reset coefficients pass samples straight through all three sections
		plan = '{
			known_row(32767, 1'b0, 32767, 1'b0),
			known_row(-32768, 1'b0, -32768, 1'b0),
			known_row(0, 1'b0, 0, 1'b0),
			known_row(-1, 1'b0, -1, 1'b0),
			known_row(1, 1'b1, 1, 1'b0),
			cfg_row(REG_SPARE_6, 'hFFFFFF),
			cfg_row(REG_SPARE_7, 'h5A5A5A),
			known_row(12345, 1'b0, 12345, 1'b0),
			cfg_row(cbq_pkg::REG_B0, 8388607),
			known_row(20000, 1'b0, 32767, 1'b1),
			known_row(-20000, 1'b0, -32768, 1'b1),
			item_row(100, 1'b0),
			cfg_row(cbq_pkg::REG_B0, -8388608),
			known_row(-32768, 1'b0, 32767, 1'b1),
			// count of zero with junk in the upper bits acts as one section
			cfg_row(cbq_pkg::REG_SECTIONS, 'hFFFFFC),
			known_row(1000, 1'b0, -2000, 1'b0),
			cfg_row(cbq_pkg::REG_B0, COEF_ONE),
			cfg_row(cbq_pkg::REG_B1, COEF_ONE / 2),
			cfg_row(cbq_pkg::REG_B2, -COEF_ONE / 2),
			cfg_row(cbq_pkg::REG_A1, -8388608),
			cfg_row(cbq_pkg::REG_A2, COEF_ONE - 1),
			item_row(30000, 1'b1),
			item_row(30000, 1'b0),
			item_row(-32768, 1'b0),
			item_row(30000, 1'b0),
			// back to three sections: the idle ones still hold the history cleared at the last restart
			cfg_row(cbq_pkg::REG_SECTIONS, 3),
			item_row(500, 1'b0),
			item_row(-500, 1'b0),
			item_row(7, 1'b1)
		};

		n_items = 0;
		for (r = 0; r < PLAN_ROWS; r++)
			if (plan[r].kind == ROW_ITEM)
				n_items++;
		hold_trigger = n_items + 4 * PHASE_ITEMS + PHASE_ITEMS / 2;
		tx_idle_pct = 35;
		rx_idle_pct = 48;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].kind == ROW_CFG) begin
				drain();
				write_reg(plan[r].idx, plan[r].data);
			end else
				send_sample(plan[r].sample, plan[r].sos, plan[r].known,
					'{plan[r].want, plan[r].want_clip});
		end

		for (p = 0; p < PHASES; p++) begin
			drain();
			@(posedge clk);
			tx_idle_pct = (p < 3) ? 35 : (p < 6) ? 48 : 0;
			rx_idle_pct = (p < 3) ? 48 : (p < 6) ? 35 : 0;
			@(negedge clk);
			case (p)
				0: setting = stable_setting(2'd3, COEF_ONE / 2);
				1: setting = stable_setting(2'd1, COEF_ONE / 2);
				2: setting = '{2'd2, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
				3: setting = stable_setting(2'd0, COEF_ONE / 2);
				4: setting = stable_setting(2'd3, COEF_ONE / 4);
				5: setting = '{SEL_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
					COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom)};
				6: setting = '{2'd3, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN};
				default: setting = stable_setting(2'd3, int'(COEF_MAX));
			endcase
			write_reg(cbq_pkg::REG_SECTIONS,
				{(CFG_DATA_W - SEL_W)'($urandom), setting.sections});
			write_reg(cbq_pkg::REG_B0, setting.b0);
			write_reg(cbq_pkg::REG_B1, setting.b1);
			write_reg(cbq_pkg::REG_B2, setting.b2);
			write_reg(cbq_pkg::REG_A1, setting.a1);
			write_reg(cbq_pkg::REG_A2, setting.a2);
			// open each phase with a fresh stream, restart now and then
			for (i = 0; i < PHASE_ITEMS; i++)
				send_sample(draw_sample(), (i == 0) || ($urandom_range(39) == 0), 1'b0, '0);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
